FILE: sv/fpl_pkg.sv
// package for the frame plane layout block: transaction types, format and status codes
// and the line alignment helper; no dependencies
`default_nettype none

package fpl_pkg;

  // line pitch alignment in bytes, a power of two
  localparam int unsigned StrideAlign = 64;
  localparam logic [17:0] AlignAdd    = 18'(StrideAlign - 1);

  // pixel format codes
  localparam logic [2:0] FmtRgb888   = 3'd0;
  localparam logic [2:0] FmtBgr888   = 3'd1;
  localparam logic [2:0] FmtRgba8888 = 3'd2;
  localparam logic [2:0] FmtRaw8     = 3'd3;
  localparam logic [2:0] FmtYuv420p  = 3'd4;
  localparam logic [2:0] FmtNv12     = 3'd5;

  // status codes
  localparam logic [1:0] StatusOk        = 2'd0;
  localparam logic [1:0] StatusZeroDim   = 2'd1;
  localparam logic [1:0] StatusBadFormat = 2'd2;

  typedef struct packed {
    logic [13:0] frame_width;
    logic [13:0] frame_height;
    logic [2:0]  pixel_format;
  } fpl_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [1:0]  plane_count;
    logic [15:0] luma_line_bytes;
    logic [16:0] luma_stride;
    logic [29:0] luma_plane_bytes;
    logic [13:0] chroma_line_bytes;
    logic [14:0] chroma_stride;
    logic [29:0] chroma_one_bytes;
    logic [14:0] chroma_two_stride;
    logic [29:0] chroma_two_bytes;
    logic [12:0] chroma_rows;
    logic [30:0] frame_bytes;
  } fpl_rsp_t;

  // line geometry handed from the format decode to the size calculation
  typedef struct packed {
    logic [1:0]  status;
    logic [1:0]  plane_count;
    logic [15:0] luma_line_bytes;
    logic [16:0] luma_stride;
    logic [13:0] luma_rows;
    logic [13:0] chroma_line_bytes;
    logic [14:0] chroma_stride;
    logic [12:0] chroma_rows;
    logic        chroma_two_en;
  } fpl_line_t;

  // round a byte count up to the next multiple of the alignment
  function automatic logic [17:0] align_up(logic [17:0] x);
    return (x + AlignAdd) & ~AlignAdd;
  endfunction

endpackage

`default_nettype wire

FILE: sv/fpl_line.sv
// format decode, line bytes and aligned strides of all planes
// depends on fpl_pkg
`default_nettype none

module fpl_line
  import fpl_pkg::*;
(
  input  fpl_req_t  req_i,
  output fpl_line_t line_o
);

  logic [15:0] width_ext;
  logic [15:0] width_x3;
  logic [15:0] width_x4;
  logic        zero_dim;
  logic [15:0] luma_line;
  logic [13:0] chroma_line;
  logic [17:0] luma_aligned;
  logic [17:0] chroma_aligned;

  assign width_ext = {2'b00, req_i.frame_width};
  assign width_x3  = (width_ext << 1) + width_ext;
  assign width_x4  = width_ext << 2;
  assign zero_dim  = (req_i.frame_width == '0) || (req_i.frame_height == '0);

  always_comb begin
    luma_line                = '0;
    chroma_line              = '0;
    line_o.status            = StatusOk;
    line_o.plane_count       = '0;
    line_o.luma_rows         = '0;
    line_o.chroma_rows       = '0;
    line_o.chroma_two_en     = 1'b0;
    if (zero_dim) begin
      line_o.status = StatusZeroDim;
    end else begin
      case (req_i.pixel_format)
        FmtRgb888, FmtBgr888: begin
          line_o.plane_count = 2'd1;
          luma_line          = width_x3;
          line_o.luma_rows   = req_i.frame_height;
        end
        FmtRgba8888: begin
          line_o.plane_count = 2'd1;
          luma_line          = width_x4;
          line_o.luma_rows   = req_i.frame_height;
        end
        FmtRaw8: begin
          line_o.plane_count = 2'd1;
          luma_line          = width_ext;
          line_o.luma_rows   = req_i.frame_height;
        end
        FmtYuv420p: begin
          line_o.plane_count   = 2'd3;
          luma_line            = width_ext;
          line_o.luma_rows     = req_i.frame_height;
          chroma_line          = req_i.frame_width >> 1;
          line_o.chroma_rows   = req_i.frame_height[13:1];
          line_o.chroma_two_en = 1'b1;
        end
        FmtNv12: begin
          line_o.plane_count = 2'd2;
          luma_line          = width_ext;
          line_o.luma_rows   = req_i.frame_height;
          chroma_line        = req_i.frame_width;
          line_o.chroma_rows = req_i.frame_height[13:1];
        end
        default: begin
          line_o.status = StatusBadFormat;
        end
      endcase
    end

    // a zero line aligns to zero, so unused planes stay zero
    luma_aligned             = align_up({2'b00, luma_line});
    chroma_aligned           = align_up({4'b0000, chroma_line});
    line_o.luma_line_bytes   = luma_line;
    line_o.chroma_line_bytes = chroma_line;
    line_o.luma_stride       = luma_aligned[16:0];
    line_o.chroma_stride     = chroma_aligned[14:0];
  end

endmodule

`default_nettype wire

FILE: sv/fpl_size.sv
// plane sizes from stride times rows and the frame total
// depends on fpl_pkg
`default_nettype none

module fpl_size
  import fpl_pkg::*;
(
  input  fpl_line_t line_i,
  output fpl_rsp_t  rsp_o
);

  logic [30:0] luma_prod;
  logic [27:0] chroma_prod;
  logic [29:0] chroma_bytes;
  logic [29:0] two_bytes;

  assign luma_prod    = 31'(line_i.luma_stride) * 31'(line_i.luma_rows);
  assign chroma_prod  = 28'(line_i.chroma_stride) * 28'(line_i.chroma_rows);
  assign chroma_bytes = {2'b00, chroma_prod};
  assign two_bytes    = line_i.chroma_two_en ? chroma_bytes : '0;

  always_comb begin
    rsp_o.status            = line_i.status;
    rsp_o.plane_count       = line_i.plane_count;
    rsp_o.luma_line_bytes   = line_i.luma_line_bytes;
    rsp_o.luma_stride       = line_i.luma_stride;
    rsp_o.luma_plane_bytes  = luma_prod[29:0];
    rsp_o.chroma_line_bytes = line_i.chroma_line_bytes;
    rsp_o.chroma_stride     = line_i.chroma_stride;
    rsp_o.chroma_one_bytes  = chroma_bytes;
    rsp_o.chroma_two_stride = line_i.chroma_two_en ? line_i.chroma_stride : '0;
    rsp_o.chroma_two_bytes  = two_bytes;
    rsp_o.chroma_rows       = line_i.chroma_rows;
    rsp_o.frame_bytes       = {1'b0, luma_prod[29:0]} + {1'b0, chroma_bytes}
                              + {1'b0, two_bytes};
  end

endmodule

`default_nettype wire

FILE: sv/frame_plane_layout.sv
// top level of the frame plane layout block: request register, layout logic, result register
// depends on fpl_pkg, fpl_line and fpl_size
`default_nettype none

// Frame plane layout. Each request transaction carries a frame width, height
// and pixel format; the block answers with one result transaction giving line
// bytes, aligned stride (64-byte pitch), plane size per plane and the frame
// total. Packed formats use one plane, NV12 two, YUV420P three; a zero width or
// height reports status 1 and an unknown format status 2, with all other fields
// zero. An accepted request is held in the request register, then the decode,
// the stride-times-rows multipliers and the sum feed the result register;
// backpressure on the result side can hold it there. A new request is taken
// every cycle; throughput is one transaction per cycle, limited only by
// backpressure on the result side. The block keeps no state between requests.

module frame_plane_layout
  import fpl_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  fpl_req_t in_req_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output fpl_rsp_t out_rsp_o
);

  // request stage
  logic      req_valid_q;
  fpl_req_t  req_q;
  // result stage
  logic      rsp_valid_q;
  fpl_rsp_t  rsp_q;

  fpl_line_t line;
  fpl_rsp_t  rsp_d;
  logic      advance;

  // the result register can load when empty or being drained this cycle
  assign advance    = !rsp_valid_q || out_ready_i;
  // the request register frees up when it moves forward or holds nothing
  assign in_ready_o = advance || !req_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      req_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      req_q <= in_req_i;
    end
  end

  // format decode and strides
  fpl_line u_line (
    .req_i  (req_q),
    .line_o (line)
  );

  // plane sizes and total
  fpl_size u_size (
    .line_i (line),
    .rsp_o  (rsp_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (advance) begin
      rsp_valid_q <= req_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && req_valid_q) begin
      rsp_q <= rsp_d;
    end
  end

  assign out_valid_o = rsp_valid_q;
  assign out_rsp_o   = rsp_q;

`ifndef SYNTHESIS
  // an error result carries nothing but its status
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_rsp_o.status != StatusOk)
      |-> (out_rsp_o.plane_count == '0) && (out_rsp_o.frame_bytes == '0)
          && (out_rsp_o.luma_stride == '0))
    else $error("error result with nonzero layout");

  // a good result has planes and a pitch that covers the line
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_rsp_o.status == StatusOk)
      |-> (out_rsp_o.plane_count != '0)
          && ({1'b0, out_rsp_o.luma_line_bytes} <= out_rsp_o.luma_stride))
    else $error("ok result with bad luma geometry");

  // plane two only exists for the three-plane format
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_rsp_o.plane_count != 2'd3)
      |-> (out_rsp_o.chroma_two_stride == '0) && (out_rsp_o.chroma_two_bytes == '0))
    else $error("plane two set without three planes");

  // a waiting request moves into an emptied result register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_q && advance |=> out_valid_o)
    else $error("request lost between stages");
`endif

endmodule

`default_nettype wire
